>>> sv/assert_macros.svh
// Assertion shorthands shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RBFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define RBFM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rbfm_pkg.sv
// ----------------------------------------------------------------------------
// rbfm_pkg
// Shared constants, codes and helper functions of the run-length FM-index
// rank block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbfm_pkg;

  localparam int STORE_DEPTH_DEF  = 65536;
  localparam int SAMPLE_DEPTH_DEF = 4096;
  localparam int SYMBOL_COUNT_DEF = 6;
  localparam int SYMBOL_BITS_DEF  = 3;

  localparam int CNT_W   = 40;  // counts and range ends
  localparam int POS_W   = 43;  // scan position and offset total
  localparam int P_W     = 41;  // unmasked position sum used by the bin flush
  localparam int SHIFT_W = 6;
  localparam int BYTE_W  = 8;
  localparam int QSYM_W  = 3;
  localparam int PWR_W   = 5;

  localparam logic [PWR_W-1:0] PWR_MIN   = 5'd4;
  localparam logic [PWR_W-1:0] PWR_MAX   = 5'd16;
  localparam logic [PWR_W-1:0] PWR_RESET = 5'd8;

  localparam int CFG_BIN_POWER = 0;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_t;

  typedef struct packed {
    logic init;
    logic step;
  } scan_ctl_t;

  function automatic logic [PWR_W-1:0] eff_power(input logic [PWR_W-1:0] bp);
    if (bp < PWR_MIN) return PWR_MIN;
    if (bp > PWR_MAX) return PWR_MAX;
    return bp;
  endfunction

  // Symbol code of a byte; codes past the alphabet fold onto the last symbol.
  function automatic logic [3:0] sym_of(input logic [BYTE_W-1:0] code,
                                        input int sb, input int sc);
    logic [BYTE_W-1:0] s;
    s = code & BYTE_W'((1 << sb) - 1);
    if (int'(s) >= sc) s = BYTE_W'(sc - 1);
    return s[3:0];
  endfunction

  function automatic logic [CNT_W-1:0] digit_val(input logic [BYTE_W-1:0] b,
                                                 input logic [SHIFT_W-1:0] sh,
                                                 input int sb);
    logic [CNT_W-1:0] d;
    d = CNT_W'(b >> sb);
    return (sh < SHIFT_W'(CNT_W)) ? (d << sh) : '0;
  endfunction

  function automatic logic [SHIFT_W-1:0] next_shift(input logic [SHIFT_W-1:0] sh,
                                                    input int db);
    logic [SHIFT_W:0] t;
    t = (SHIFT_W+1)'(sh) + (SHIFT_W+1)'(db);
    return (t > (SHIFT_W+1)'(CNT_W)) ? SHIFT_W'(CNT_W) : t[SHIFT_W-1:0];
  endfunction

endpackage

>>> sv/rbfm_ram.sv
// ----------------------------------------------------------------------------
// rbfm_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbfm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> sv/rbfm_scan.sv
// ----------------------------------------------------------------------------
// rbfm_scan
// Run scanner: walks coded bytes from a sampled bin, one byte per step,
// tracking position, current run length and the rank of the query symbol.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbfm_scan #(
  parameter int STORE_DEPTH  = rbfm_pkg::STORE_DEPTH_DEF,
  parameter int SYMBOL_COUNT = rbfm_pkg::SYMBOL_COUNT_DEF,
  parameter int SYMBOL_BITS  = rbfm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rbfm_pkg::scan_ctl_t                ctl,
  input  logic [rbfm_pkg::POS_W-1:0]         init_pos,
  input  logic [$clog2(STORE_DEPTH):0]       init_idx,
  input  logic [rbfm_pkg::CNT_W-1:0]         init_acc,
  input  logic [$clog2(SYMBOL_COUNT)-1:0]    sym,
  input  logic [rbfm_pkg::BYTE_W-1:0]        rd_byte,
  output logic [rbfm_pkg::POS_W-1:0]         pos,
  output logic [rbfm_pkg::CNT_W-1:0]         cnt,
  output logic [$clog2(STORE_DEPTH):0]       idx,
  output logic [rbfm_pkg::CNT_W-1:0]         acc,
  output logic                               hit
);

  localparam int BC_W = $clog2(STORE_DEPTH) + 1;
  localparam int SI_W = $clog2(SYMBOL_COUNT);
  localparam int DB   = rbfm_pkg::BYTE_W - SYMBOL_BITS;

  logic [rbfm_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [rbfm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BC_W-1:0]              idx_r, idx_nxt;
  logic [rbfm_pkg::CNT_W-1:0]   acc_r, acc_nxt;
  logic [SI_W-1:0]              prev_r, prev_nxt;
  logic [rbfm_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic                         have_r, have_nxt;
  logic [3:0]                   c4;
  logic [SI_W-1:0]              c;

  assign c4 = rbfm_pkg::sym_of(rd_byte, SYMBOL_BITS, SYMBOL_COUNT);
  assign c  = c4[SI_W-1:0];

  always_comb begin
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    prev_nxt  = prev_r;
    shift_nxt = shift_r;
    have_nxt  = have_r;
    if (ctl.init) begin
      pos_nxt   = init_pos;
      cnt_nxt   = '0;
      idx_nxt   = init_idx;
      acc_nxt   = init_acc;
      prev_nxt  = '0;
      shift_nxt = '0;
      have_nxt  = 1'b0;
    end else if (ctl.step) begin
      if (have_r && c == prev_r) begin
        // Another digit of the same run.
        cnt_nxt   = cnt_r + rbfm_pkg::digit_val(rd_byte, shift_r, SYMBOL_BITS);
        shift_nxt = rbfm_pkg::next_shift(shift_r, DB);
      end else begin
        if (have_r && prev_r == sym) acc_nxt = acc_r + cnt_r;
        pos_nxt   = pos_r + rbfm_pkg::POS_W'(cnt_r);
        cnt_nxt   = rbfm_pkg::digit_val(rd_byte, '0, SYMBOL_BITS);
        prev_nxt  = c;
        have_nxt  = 1'b1;
        shift_nxt = rbfm_pkg::SHIFT_W'(DB);
      end
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    prev_r  <= prev_nxt;
    shift_r <= shift_nxt;
  end

  assign pos = pos_r;
  assign cnt = cnt_r;
  assign idx = idx_r;
  assign acc = acc_r;
  assign hit = have_r && (prev_r == sym);

endmodule

>>> sv/rle_bwt_fm_index_rank_top.sv
// ----------------------------------------------------------------------------
// rle_bwt_fm_index_rank_top
// Builds sampled rank bins over a run-length coded BWT and answers
// backward-search range queries by scanning runs from the sampled bins.
//
//   channel  dir  handshake             word
//   in_      in   in_valid / in_ready   command, coded byte, symbol, range
//   out_     out  out_valid / out_ready new range ends, status
//   cfg_     in   cfg_we                register index, write data
//
// One word is in flight at a time. An append of a repeated symbol goes
// straight from dispatch to done; a new run or a finish first writes each
// bin that it passes, and a finish then totals the counts of the first bin.
// A query totals the counts of the sampled bin of each range end and then
// scans coded bytes from it, each read from the byte store before a step.
// Reset is synchronous; the memories need no clearing. A stalled result
// waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_bwt_fm_index_rank_top #(
  parameter int STORE_DEPTH  = rbfm_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_DEPTH = rbfm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SYMBOL_COUNT = rbfm_pkg::SYMBOL_COUNT_DEF,
  parameter int SYMBOL_BITS  = rbfm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic [rbfm_pkg::BYTE_W-1:0]         in_coded_byte,
  input  logic [rbfm_pkg::QSYM_W-1:0]         in_query_symbol,
  input  logic [rbfm_pkg::CNT_W-1:0]          in_range_low,
  input  logic [rbfm_pkg::CNT_W-1:0]          in_range_high,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rbfm_pkg::CNT_W-1:0]          out_new_low,
  output logic [rbfm_pkg::CNT_W-1:0]          out_new_high,
  output logic [1:0]                          out_status,
  input  logic                                cfg_we,
  input  logic [$clog2(SYMBOL_COUNT+1)-1:0]   cfg_index,
  input  logic [rbfm_pkg::CNT_W-1:0]          cfg_wdata
);

  localparam int CNT_W = rbfm_pkg::CNT_W;
  localparam int POS_W = rbfm_pkg::POS_W;
  localparam int P_W   = rbfm_pkg::P_W;
  localparam int ST_AW = $clog2(STORE_DEPTH);
  localparam int BC_W  = ST_AW + 1;
  localparam int SM_AW = $clog2(SAMPLE_DEPTH);
  localparam int SI_W  = $clog2(SYMBOL_COUNT);
  localparam int CFG_W = $clog2(SYMBOL_COUNT + 1);
  localparam int DB    = rbfm_pkg::BYTE_W - SYMBOL_BITS;
  localparam int ROW_W = SYMBOL_COUNT * CNT_W + BC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FL_DIFF, S_FL_NEED, S_FL_CHK, S_FL_WR, S_FL_DONE,
    S_FIN_RD, S_Q_START, S_Q_RD, S_SUM, S_SUM_END, S_SC_CHK, S_SC_STEP,
    S_SC_END, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Build state.
  logic [rbfm_pkg::PWR_W-1:0]   bin_power_r, bin_power_nxt;
  logic [CNT_W-1:0]             running_r [SYMBOL_COUNT];
  logic [CNT_W-1:0]             running_nxt [SYMBOL_COUNT];
  logic [SI_W-1:0]              prev_r, prev_nxt;
  logic [CNT_W-1:0]             run_total_r, run_total_nxt;
  logic [rbfm_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [P_W-1:0]               bin_end_r, bin_end_nxt;
  logic [SM_AW-1:0]             bin_number_r, bin_number_nxt;
  logic [CNT_W-1:0]             position_sum_r, position_sum_nxt;
  logic [BC_W-1:0]              run_start_r, run_start_nxt;
  logic [BC_W-1:0]              byte_count_r, byte_count_nxt;
  logic [POS_W-1:0]             offset_r, offset_nxt;
  logic                         ready_r, ready_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Per-word working registers.
  rbfm_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [rbfm_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic [SI_W-1:0]              qsym_r, qsym_nxt;
  logic [CNT_W-1:0]             low_r, low_nxt, high_r, high_nxt;
  logic [P_W-1:0]               p_r, p_nxt, diff_r, diff_nxt, need_r, need_nxt;
  logic [SM_AW-1:0]             b_r, b_nxt, bh_r, bh_nxt;
  logic                         pass_r, pass_nxt;
  logic [SI_W-1:0]              k_r, k_nxt;
  logic [POS_W-1:0]             sum_r, sum_nxt;
  logic [CNT_W-1:0]             res_low_r, res_low_nxt, res_high_r, res_high_nxt;
  rbfm_pkg::status_t            res_status_r, res_status_nxt;
  logic [CNT_W-1:0]             out_low_r, out_high_r;
  rbfm_pkg::status_t            out_status_r;
  logic                         out_load;

  // Memory and scanner hookup.
  logic                         st_we, st_re, sm_we, sm_re;
  logic [rbfm_pkg::BYTE_W-1:0]  st_rdata;
  logic [SM_AW-1:0]             sm_raddr;
  logic [ROW_W-1:0]             sm_rdata, wr_row;
  logic [CNT_W-1:0]             cnt_row [SYMBOL_COUNT];
  logic [BC_W-1:0]              row_ptr;
  logic                         end_entry;
  rbfm_pkg::scan_ctl_t          sc_ctl;
  logic [POS_W-1:0]             sc_pos;
  logic [CNT_W-1:0]             sc_cnt, sc_acc;
  logic [BC_W-1:0]              sc_idx;
  logic                         sc_hit;

  logic [rbfm_pkg::PWR_W-1:0]   pw;
  logic [3:0]                   byte_sym4, qsym4;
  logic [SI_W-1:0]              byte_sym;
  logic [CNT_W-1:0]             lsh, hsh, target, scan_val;
  logic                         scan_more;

  assign pw        = rbfm_pkg::eff_power(bin_power_r);
  assign byte_sym4 = rbfm_pkg::sym_of(byte_r, SYMBOL_BITS, SYMBOL_COUNT);
  assign byte_sym  = byte_sym4[SI_W-1:0];
  assign qsym4     = rbfm_pkg::sym_of({{(rbfm_pkg::BYTE_W-rbfm_pkg::QSYM_W){1'b0}},
                                       in_query_symbol}, SYMBOL_BITS, SYMBOL_COUNT);
  assign lsh       = low_r >> pw;
  assign hsh       = high_r >> pw;
  assign target    = pass_r ? high_r : low_r;
  assign scan_more = (({1'b0, sc_pos} + (POS_W+1)'(sc_cnt)) < (POS_W+1)'(target)) &&
                     (sc_idx < byte_count_r);
  // Positions past the last run boundary belong to the open run.
  assign scan_val  = sc_acc + (sc_hit ? (target - sc_pos[CNT_W-1:0]) : '0);
  assign end_entry = (state_r == S_FL_DONE);
  assign row_ptr   = sm_rdata[ROW_W-1 -: BC_W];

  always_comb begin
    for (int k = 0; k < SYMBOL_COUNT; k++) begin
      cnt_row[k] = sm_rdata[k*CNT_W +: CNT_W];
      wr_row[k*CNT_W +: CNT_W] = running_r[k] +
        ((end_entry && prev_r == SI_W'(k)) ? run_total_r : '0);
    end
    wr_row[ROW_W-1 -: BC_W] = end_entry ? byte_count_r : run_start_r;
  end

  always_comb begin
    state_nxt        = state_r;
    bin_power_nxt    = bin_power_r;
    running_nxt      = running_r;
    prev_nxt         = prev_r;
    run_total_nxt    = run_total_r;
    shift_nxt        = shift_r;
    bin_end_nxt      = bin_end_r;
    bin_number_nxt   = bin_number_r;
    position_sum_nxt = position_sum_r;
    run_start_nxt    = run_start_r;
    byte_count_nxt   = byte_count_r;
    offset_nxt       = offset_r;
    ready_nxt        = ready_r;
    cmd_nxt          = cmd_r;
    byte_nxt         = byte_r;
    qsym_nxt         = qsym_r;
    low_nxt          = low_r;
    high_nxt         = high_r;
    p_nxt            = p_r;
    diff_nxt         = diff_r;
    need_nxt         = need_r;
    b_nxt            = b_r;
    bh_nxt           = bh_r;
    pass_nxt         = pass_r;
    k_nxt            = k_r;
    sum_nxt          = sum_r;
    res_low_nxt      = res_low_r;
    res_high_nxt     = res_high_r;
    res_status_nxt   = res_status_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_load         = 1'b0;
    st_we            = 1'b0;
    st_re            = 1'b0;
    sm_we            = 1'b0;
    sm_re            = 1'b0;
    sm_raddr         = '0;
    sc_ctl           = '0;

    if (cfg_we) begin
      if (cfg_index == CFG_W'(rbfm_pkg::CFG_BIN_POWER)) begin
        bin_power_nxt = cfg_wdata[rbfm_pkg::PWR_W-1:0];
      end
      // Start counts seed the running counts only before the first bin.
      for (int k = 0; k < SYMBOL_COUNT; k++) begin
        if (cfg_index == CFG_W'(k + 1) && bin_number_r == '0) running_nxt[k] = cfg_wdata;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = rbfm_pkg::cmd_t'(in_command);
          byte_nxt       = in_coded_byte;
          qsym_nxt       = qsym4[SI_W-1:0];
          low_nxt        = in_range_low;
          high_nxt       = in_range_high;
          res_low_nxt    = '0;
          res_high_nxt   = '0;
          res_status_nxt = rbfm_pkg::STAT_OK;
          state_nxt      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        p_nxt = P_W'(position_sum_r) + P_W'(run_total_r);
        case (cmd_r)
          rbfm_pkg::CMD_APPEND: begin
            if (byte_count_r >= BC_W'(STORE_DEPTH)) begin
              res_status_nxt = rbfm_pkg::STAT_FULL;
              state_nxt      = S_DONE;
            end else if (byte_sym == prev_r) begin
              run_total_nxt  = run_total_r + rbfm_pkg::digit_val(byte_r, shift_r, SYMBOL_BITS);
              shift_nxt      = rbfm_pkg::next_shift(shift_r, DB);
              st_we          = 1'b1;
              byte_count_nxt = byte_count_r + 1'b1;
              ready_nxt      = 1'b0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_FL_DIFF;
            end
          end
          rbfm_pkg::CMD_FINISH: state_nxt = S_FL_DIFF;
          rbfm_pkg::CMD_QUERY: begin
            if (!ready_r) begin
              res_status_nxt = rbfm_pkg::STAT_NOT_READY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_Q_START;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FL_DIFF: begin
        if (p_r < bin_end_r) begin
          state_nxt = S_FL_DONE;
        end else begin
          diff_nxt  = p_r - bin_end_r;
          state_nxt = S_FL_NEED;
        end
      end
      S_FL_NEED: begin
        need_nxt  = (diff_r >> pw) + P_W'(1);
        state_nxt = S_FL_CHK;
      end
      S_FL_CHK: begin
        // The last sample entry stays free for the end entry.
        if ((P_W+1)'(bin_number_r) + (P_W+1)'(need_r) > (P_W+1)'(SAMPLE_DEPTH - 1)) begin
          res_status_nxt = rbfm_pkg::STAT_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_FL_WR;
        end
      end
      S_FL_WR: begin
        sm_we          = 1'b1;
        bin_end_nxt    = bin_end_r + (P_W'(1) << pw);
        bin_number_nxt = bin_number_r + 1'b1;
        need_nxt       = need_r - P_W'(1);
        if (need_r == P_W'(1)) state_nxt = S_FL_DONE;
      end
      S_FL_DONE: begin
        if (cmd_r == rbfm_pkg::CMD_APPEND) begin
          running_nxt[prev_r] = running_r[prev_r] + run_total_r;
          position_sum_nxt    = p_r[CNT_W-1:0];
          prev_nxt            = byte_sym;
          run_start_nxt       = byte_count_r;
          run_total_nxt       = rbfm_pkg::digit_val(byte_r, '0, SYMBOL_BITS);
          shift_nxt           = rbfm_pkg::SHIFT_W'(DB);
          st_we               = 1'b1;
          byte_count_nxt      = byte_count_r + 1'b1;
          ready_nxt           = 1'b0;
          state_nxt           = S_DONE;
        end else begin
          sm_we     = 1'b1;
          state_nxt = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        sm_re     = 1'b1;
        sm_raddr  = '0;
        k_nxt     = '0;
        sum_nxt   = '0;
        state_nxt = S_SUM;
      end
      S_Q_START: begin
        b_nxt     = (lsh > CNT_W'(bin_number_r)) ? bin_number_r : lsh[SM_AW-1:0];
        bh_nxt    = (hsh > CNT_W'(bin_number_r)) ? bin_number_r : hsh[SM_AW-1:0];
        pass_nxt  = 1'b0;
        state_nxt = S_Q_RD;
      end
      S_Q_RD: begin
        sm_re     = 1'b1;
        sm_raddr  = pass_r ? bh_r : b_r;
        k_nxt     = '0;
        sum_nxt   = '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt = sum_r + POS_W'(cnt_row[k_r]);
        k_nxt   = k_r + 1'b1;
        if (k_r == SI_W'(SYMBOL_COUNT - 1)) state_nxt = S_SUM_END;
      end
      S_SUM_END: begin
        if (cmd_r == rbfm_pkg::CMD_FINISH) begin
          offset_nxt = sum_r;
          ready_nxt  = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          sc_ctl.init = 1'b1;
          state_nxt   = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (scan_more) begin
          st_re     = 1'b1;
          state_nxt = S_SC_STEP;
        end else begin
          state_nxt = S_SC_END;
        end
      end
      S_SC_STEP: begin
        sc_ctl.step = 1'b1;
        state_nxt   = S_SC_CHK;
      end
      S_SC_END: begin
        if (!pass_r) begin
          res_low_nxt = scan_val;
          pass_nxt    = 1'b1;
          // Same bin: keep scanning from where the low end stopped.
          state_nxt   = (b_r == bh_r) ? S_SC_CHK : S_Q_RD;
        end else begin
          res_high_nxt = scan_val;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      bin_power_r    <= rbfm_pkg::PWR_RESET;
      for (int k = 0; k < SYMBOL_COUNT; k++) running_r[k] <= '0;
      prev_r         <= '0;
      run_total_r    <= '0;
      shift_r        <= '0;
      bin_end_r      <= '0;
      bin_number_r   <= '0;
      position_sum_r <= '0;
      run_start_r    <= '0;
      byte_count_r   <= '0;
      offset_r       <= '0;
      ready_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      bin_power_r    <= bin_power_nxt;
      running_r      <= running_nxt;
      prev_r         <= prev_nxt;
      run_total_r    <= run_total_nxt;
      shift_r        <= shift_nxt;
      bin_end_r      <= bin_end_nxt;
      bin_number_r   <= bin_number_nxt;
      position_sum_r <= position_sum_nxt;
      run_start_r    <= run_start_nxt;
      byte_count_r   <= byte_count_nxt;
      offset_r       <= offset_nxt;
      ready_r        <= ready_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    byte_r       <= byte_nxt;
    qsym_r       <= qsym_nxt;
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    p_r          <= p_nxt;
    diff_r       <= diff_nxt;
    need_r       <= need_nxt;
    b_r          <= b_nxt;
    bh_r         <= bh_nxt;
    pass_r       <= pass_nxt;
    k_r          <= k_nxt;
    sum_r        <= sum_nxt;
    res_low_r    <= res_low_nxt;
    res_high_r   <= res_high_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_low_r    <= res_low_r;
      out_high_r   <= res_high_r;
      out_status_r <= res_status_r;
    end
  end

  rbfm_ram #(.DEPTH(STORE_DEPTH), .WIDTH(rbfm_pkg::BYTE_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (byte_count_r[ST_AW-1:0]),
    .wdata (byte_r),
    .re    (st_re),
    .raddr (sc_idx[ST_AW-1:0]),
    .rdata (st_rdata)
  );

  rbfm_ram #(.DEPTH(SAMPLE_DEPTH), .WIDTH(ROW_W)) u_samples (
    .clk   (clk),
    .we    (sm_we),
    .waddr (bin_number_r),
    .wdata (wr_row),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  rbfm_scan #(
    .STORE_DEPTH  (STORE_DEPTH),
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .SYMBOL_BITS  (SYMBOL_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sc_ctl),
    .init_pos (sum_r - offset_r),
    .init_idx (row_ptr),
    .init_acc (cnt_row[qsym_r]),
    .sym      (qsym_r),
    .rd_byte  (st_rdata),
    .pos      (sc_pos),
    .cnt      (sc_cnt),
    .idx      (sc_idx),
    .acc      (sc_acc),
    .hit      (sc_hit)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_new_low  = out_low_r;
  assign out_new_high = out_high_r;
  assign out_status   = out_status_r;

endmodule

>>> sv/rbfm_chk.sv
// ----------------------------------------------------------------------------
// rbfm_chk
// Port-level checks of the rank block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbfm_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rbfm_pkg::CNT_W-1:0] out_new_low,
  input logic [rbfm_pkg::CNT_W-1:0] out_new_high,
  input logic [1:0]                 out_status
);

  // A stalled result stays up with the same status.
  `RBFM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status), "result dropped while stalled")

  // A taken word moves the block out of idle, so ready falls after a handshake.
  `RBFM_ASSERT(a_one_word, in_valid && in_ready |=> !in_ready, "second word taken while busy")

  // A refused word never carries a range.
  `RBFM_ASSERT(a_err_zero, out_valid && out_status != rbfm_pkg::STAT_OK |-> out_new_low == '0 && out_new_high == '0, "range on a refused word")

  `RBFM_ASSERT(a_status_code, out_valid |-> out_status <= rbfm_pkg::STAT_NOT_READY, "unknown status code")

  `RBFM_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind rle_bwt_fm_index_rank_top rbfm_chk u_chk (.*);

>>> dv/rbfm_rank_scoreboard.sv
// ----------------------------------------------------------------------------
// rbfm_rank_scoreboard
// Watches the configuration port and both word channels of the run-length
// FM-index rank block. It keeps its own copy of the index build and answers
// each accepted word in the same way. Every result word is then checked
// against the oldest answer still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbfm_rank_scoreboard
  import rbfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_coded_byte,
  input  logic [2:0]       in_query_symbol,
  input  logic [39:0]      in_range_low,
  input  logic [39:0]      in_range_high,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [39:0]      out_new_low,
  input  logic [39:0]      out_new_high,
  input  logic [1:0]       out_status,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [39:0]      cfg_wdata,
  output int               mismatches,
  output int               outstanding
);

  localparam int NSYM        = 6;
  localparam int NBYTES_MAX  = 65536;
  localparam int NBINS       = 4096;
  localparam int START_REG0  = CFG_BIN_POWER + 1;
  localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
  localparam longint unsigned MASK43 = 64'h7FF_FFFF_FFFF;

  typedef struct {
    logic [39:0] lo;
    logic [39:0] hi;
    status_t     st;
  } range_word_t;

  range_word_t range_fifo[$];

  bit [4:0]  bin_pow;
  bit [39:0] start_cnt[NSYM];
  bit [7:0]  byte_mem[NBYTES_MAX];
  bit [39:0] bin_cnt[NBINS][NSYM];
  bit [16:0] bin_ptr[NBINS];
  bit [39:0] live_cnt[NSYM];
  int unsigned     cur_sym, cur_shift, bins_done, run_first, bytes_held;
  longint unsigned run_len, next_bin_pos, pos_base, base_total;
  bit              armed;

  // Run scanner state, shared by the low and high end of a query.
  longint unsigned sc_pos, sc_len;
  int unsigned     sc_idx, sc_sym, sc_shift;
  bit              sc_have;

  function automatic int unsigned used_power();
    if (bin_pow < 4) return 4;
    if (bin_pow > 16) return 16;
    return bin_pow;
  endfunction

  function automatic int unsigned fold_sym(input bit [7:0] code);
    int unsigned s;
    s = code & 8'h07;
    return (s >= NSYM) ? NSYM - 1 : s;
  endfunction

  function automatic longint unsigned digit_of(input bit [7:0] b, input int unsigned sh);
    longint unsigned d;
    d = b >> 3;
    return (sh < 40) ? ((d << sh) & MASK40) : 0;
  endfunction

  function automatic int unsigned shift_up(input int unsigned sh);
    return (sh + 5 > 40) ? 40 : sh + 5;
  endfunction

  function automatic void clear_model();
    bin_pow = PWR_RESET;
    foreach (start_cnt[y]) begin
      start_cnt[y] = '0;
      live_cnt[y] = '0;
    end
    cur_sym = 0;
    cur_shift = 0;
    bins_done = 0;
    run_first = 0;
    bytes_held = 0;
    run_len = 0;
    next_bin_pos = 0;
    pos_base = 0;
    base_total = 0;
    armed = 1'b0;
  endfunction

  // Writes every bin that ends at or before position p, or refuses the lot.
  function automatic bit write_bins(input longint unsigned p);
    int unsigned pw;
    longint unsigned need;
    pw = used_power();
    if (p < next_bin_pos) return 1'b1;
    need = ((p - next_bin_pos) >> pw) + 1;
    if (longint'(bins_done) + need > NBINS - 1) return 1'b0;
    repeat (int'(need)) begin
      bin_ptr[bins_done] = run_first;
      for (int y = 0; y < NSYM; y++) bin_cnt[bins_done][y] = live_cnt[y];
      next_bin_pos += longint'(1) << pw;
      bins_done++;
    end
    return 1'b1;
  endfunction

  function automatic void scan_from(input int unsigned b);
    longint unsigned sum;
    sum = 0;
    for (int y = 0; y < NSYM; y++) sum += bin_cnt[b][y];
    sc_pos = (sum - base_total) & MASK43;
    sc_len = 0;
    sc_idx = bin_ptr[b];
    sc_sym = 0;
    sc_shift = 0;
    sc_have = 1'b0;
  endfunction

  function automatic longint unsigned scan_until(input longint unsigned target,
                                                 input int unsigned sym,
                                                 input longint unsigned acc);
    bit [7:0] b;
    int unsigned c;
    while (sc_pos + sc_len < target && sc_idx < bytes_held) begin
      b = byte_mem[sc_idx];
      c = fold_sym(b);
      if (sc_have && c == sc_sym) begin
        sc_len = (sc_len + digit_of(b, sc_shift)) & MASK40;
        sc_shift = shift_up(sc_shift);
      end else begin
        if (sc_have && sc_sym == sym) acc = (acc + sc_len) & MASK40;
        sc_pos = (sc_pos + sc_len) & MASK43;
        sc_len = digit_of(b, 0);
        sc_sym = c;
        sc_have = 1'b1;
        sc_shift = 5;
      end
      sc_idx++;
    end
    return acc;
  endfunction

  function automatic range_word_t answer_word(input cmd_t cmd, input bit [7:0] cb,
                                              input bit [2:0] qs,
                                              input longint unsigned l,
                                              input longint unsigned h);
    range_word_t r;
    int unsigned c, sym, pw;
    longint unsigned p, sum, nl, nh, keep, b, bh;
    r.lo = '0;
    r.hi = '0;
    r.st = STAT_OK;
    case (cmd)
      CMD_APPEND: begin
        c = fold_sym(cb);
        if (bytes_held >= NBYTES_MAX) begin
          r.st = STAT_FULL;
        end else if (c == cur_sym) begin
          run_len = (run_len + digit_of(cb, cur_shift)) & MASK40;
          cur_shift = shift_up(cur_shift);
          byte_mem[bytes_held++] = cb;
          armed = 1'b0;
        end else begin
          p = pos_base + run_len;
          if (!write_bins(p)) begin
            r.st = STAT_FULL;
          end else begin
            live_cnt[cur_sym] = (live_cnt[cur_sym] + run_len) & MASK40;
            pos_base = p & MASK40;
            cur_sym = c;
            run_first = bytes_held;
            run_len = digit_of(cb, 0);
            cur_shift = 5;
            byte_mem[bytes_held++] = cb;
            armed = 1'b0;
          end
        end
      end
      CMD_FINISH: begin
        if (!write_bins(pos_base + run_len)) begin
          r.st = STAT_FULL;
        end else begin
          bin_ptr[bins_done] = bytes_held;
          for (int y = 0; y < NSYM; y++) bin_cnt[bins_done][y] = live_cnt[y];
          bin_cnt[bins_done][cur_sym] = (live_cnt[cur_sym] + run_len) & MASK40;
          sum = 0;
          for (int y = 0; y < NSYM; y++) sum += bin_cnt[0][y];
          base_total = sum & MASK43;
          armed = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (!armed) begin
          r.st = STAT_NOT_READY;
        end else begin
          pw = used_power();
          sym = fold_sym({5'd0, qs});
          b = l >> pw;
          bh = h >> pw;
          if (b > bins_done) b = bins_done;
          if (bh > bins_done) bh = bins_done;
          scan_from(b);
          nl = scan_until(l, sym, bin_cnt[b][sym]);
          keep = nl;
          if (sc_have && sc_sym == sym) nl = (nl + l - sc_pos) & MASK40;
          if (b == bh) begin
            nh = keep;
          end else begin
            scan_from(bh);
            nh = bin_cnt[bh][sym];
          end
          nh = scan_until(h, sym, nh);
          if (sc_have && sc_sym == sym) nh = (nh + h - sc_pos) & MASK40;
          r.lo = nl[39:0];
          r.hi = nh[39:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    range_word_t want;
    if (!rst_n) begin
      clear_model();
      range_fifo.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BIN_POWER) begin
          bin_pow = cfg_wdata[4:0];
        end else if (cfg_index >= START_REG0 && cfg_index < START_REG0 + NSYM) begin
          start_cnt[cfg_index - START_REG0] = cfg_wdata;
          // Start counts seed the running counts only until the first bin exists.
          if (bins_done == 0) live_cnt[cfg_index - START_REG0] = cfg_wdata;
        end
      end
      if (in_valid && in_ready)
        range_fifo.push_back(answer_word(cmd_t'(in_command), in_coded_byte,
                                         in_query_symbol, in_range_low, in_range_high));
      if (out_valid && out_ready) begin
        if (range_fifo.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: result word with nothing expected: lo=%h hi=%h st=%0d",
                     out_new_low, out_new_high, out_status);
          mismatches <= mismatches + 1;
        end else begin
          want = range_fifo.pop_front();
          if (out_new_low !== want.lo || out_new_high !== want.hi ||
              out_status !== want.st) begin
            if (mismatches < 10)
              $display("ERROR: expected lo=%h hi=%h st=%0d, got lo=%h hi=%h st=%0d",
                       want.lo, want.hi, want.st, out_new_low, out_new_high, out_status);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= range_fifo.size();
  end

endmodule

>>> dv/tb_rle_bwt_fm_index_rank_top.sv
// ----------------------------------------------------------------------------
// tb_rle_bwt_fm_index_rank_top
// Drives the rank block with coded BWT runs, finish words and range queries
// over several bin sizes, with random idling on both channels. The
// scoreboard beside the block checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rle_bwt_fm_index_rank_top;
  import rbfm_pkg::*;

  localparam int START_REG0  = CFG_BIN_POWER + 1;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_command;
  logic [7:0]  in_coded_byte;
  logic [2:0]  in_query_symbol;
  logic [39:0] in_range_low, in_range_high;
  logic        out_valid, out_ready;
  logic [39:0] out_new_low, out_new_high;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [39:0] cfg_wdata;

  int mismatches, outstanding;
  int words_sent, words_back, cycles;
  int send_idle, recv_idle;
  int pos_est;
  bit hold_go;
  int hold_left = 400;

  rle_bwt_fm_index_rank_top u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_coded_byte, .in_query_symbol,
    .in_range_low, .in_range_high,
    .out_valid, .out_ready, .out_new_low, .out_new_high, .out_status,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  rbfm_rank_scoreboard u_scoreboard (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_coded_byte, .in_query_symbol,
    .in_range_low, .in_range_high,
    .out_valid, .out_ready, .out_new_low, .out_new_high, .out_status,
    .cfg_we, .cfg_index, .cfg_wdata,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rle_bwt_fm_index_rank_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) words_back <= words_back + 1;
  end

  // Receiver: one long hold-off on request, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_go && hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [7:0] cb, input logic [2:0] qs,
                           input logic [39:0] lo, input logic [39:0] hi);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_coded_byte   <= cb;
    in_query_symbol <= qs;
    in_range_low    <= lo;
    in_range_high   <= hi;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_reg(input int idx, input logic [39:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_back != words_sent) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [39:0] rand40();
    return {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
  endfunction

  // One run: a first digit and, now and then, higher digits of the same symbol.
  task automatic append_run();
    logic [2:0] sym;
    logic [4:0] d;
    int extra;
    sym = $urandom_range(7);
    d = $urandom_range(31);
    pos_est += d;
    send_word(CMD_APPEND, {d, sym}, $urandom, rand40(), rand40());
    extra = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
    for (int k = 1; k <= extra; k++) begin
      d = $urandom_range(3);
      pos_est += int'(d) << (5 * k);
      send_word(CMD_APPEND, {d, sym}, $urandom, rand40(), rand40());
    end
  endtask

  task automatic range_query();
    logic [39:0] lo, hi;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      lo = rand40();
      hi = rand40();
    end else begin
      lo = $urandom_range(pos_est);
      hi = (pick < 20 && lo > 50) ? lo - $urandom_range(1, 50) : lo + $urandom_range(300);
    end
    send_word(CMD_QUERY, $urandom, $urandom_range(7), lo, hi);
  endtask

  initial begin
    int powers[6] = '{8, 4, 16, 0, 31, 12};
    int pick, nq;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_NONE;
    in_coded_byte = '0;
    in_query_symbol = '0;
    in_range_low = '0;
    in_range_high = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles = 0;
    words_sent = 0;
    words_back = 0;
    pos_est = 0;
    hold_go = 1'b0;
    send_idle = 13;
    recv_idle = 53;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Start counts only take hold before the first bin, so set them first.
    write_reg(START_REG0, '0);
    for (int k = 1; k < 6; k++) write_reg(START_REG0 + k, $urandom_range(1 << 20));

    // Directed: query before finish, the unused command, folded symbols,
    // the byte extremes, repeated runs, and awkward ranges.
    send_word(CMD_QUERY, 8'h00, 3'd0, '0, '1);
    send_word(CMD_NONE, 8'hFF, 3'd7, '1, '1);
    send_word(CMD_APPEND, 8'h00, 3'd0, '0, '0);
    send_word(CMD_APPEND, 8'hFF, 3'd7, '1, '1);
    send_word(CMD_APPEND, {5'd3, 3'd1}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd1, 3'd1}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd9, 3'd6}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd2, 3'd5}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd7, 3'd2}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd31, 3'd3}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd4, 3'd4}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd5, 3'd0}, 3'd0, '0, '0);
    send_word(CMD_FINISH, 8'h00, 3'd0, '0, '0);
    send_word(CMD_QUERY, 8'h00, 3'd7, '0, '1);
    send_word(CMD_QUERY, 8'h00, 3'd0, 40'd3, 40'd2);
    send_word(CMD_QUERY, 8'h00, 3'd1, '0, '0);
    send_word(CMD_QUERY, 8'h00, 3'd2, 40'd5, 40'd40);
    send_word(CMD_QUERY, 8'h00, 3'd5, 40'd0, 40'd20);
    send_word(CMD_QUERY, 8'h00, 3'd6, 40'd30, 40'd100);
    send_word(CMD_FINISH, 8'h00, 3'd0, '0, '0);
    pos_est = 100;

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle = (ph < 2) ? 13 : (ph < 4) ? 53 : 0;
      recv_idle = (ph < 2) ? 53 : (ph < 4) ? 13 : 0;
      write_reg(CFG_BIN_POWER, powers[ph]);
      // Later start count writes no longer move the running counts.
      write_reg(START_REG0 + (ph % 6), (ph % 2) ? '1 : rand40());
      if (ph == 0) hold_go = 1'b1;
      for (int i = 0; i < 200; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) send_word(CMD_NONE, $urandom, $urandom, rand40(), rand40());
        else if (pick < 6) range_query();
        else if (pick < 8) send_word(CMD_FINISH, $urandom, $urandom, rand40(), rand40());
        else append_run();
      end
      send_word(CMD_FINISH, $urandom, $urandom, rand40(), rand40());
      // Wide bins make each query scan most of the store, so keep those few.
      nq = (powers[ph] >= 12) ? 8 : 90;
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(19) == 0) send_word(CMD_NONE, $urandom, $urandom, rand40(), rand40());
        else range_query();
      end
    end

    // A run long enough to push digits past 40 bits; the next run and the
    // finish then need more bins than exist and must be refused.
    settle();
    write_reg(CFG_BIN_POWER, 4);
    send_word(CMD_APPEND, {5'd1, 3'd3}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd2, 3'd4}, 3'd0, '0, '0);
    repeat (9) send_word(CMD_APPEND, {5'd31, 3'd4}, 3'd0, '0, '0);
    send_word(CMD_APPEND, {5'd1, 3'd2}, 3'd0, '0, '0);
    send_word(CMD_FINISH, 8'h00, 3'd0, '0, '0);
    send_word(CMD_QUERY, 8'h00, 3'd4, '0, 40'd10);
    send_word(CMD_NONE, 8'h00, 3'd0, '0, '0);

    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rle_bwt_fm_index_rank_top regression: pass");
    end else begin
      $display("rle_bwt_fm_index_rank_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rbfm_pkg.sv
sv/rbfm_ram.sv
sv/rbfm_scan.sv
sv/rle_bwt_fm_index_rank_top.sv
sv/rbfm_chk.sv
dv/rbfm_rank_scoreboard.sv
dv/tb_rle_bwt_fm_index_rank_top.sv
